[hw/rtl/assert_macros.svh]
// Assertion macros shared by the cohesive force limiter modules.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/ccfl_pkg.sv]
// Types and constants shared by the cohesive force limiter pipeline.
// Depends on nothing.
package ccfl_pkg;
    localparam int unsigned VAL_W  = 32;
    localparam int unsigned POS_W  = 31;
    localparam int unsigned SQ_W   = 64;
    localparam int unsigned ROOT_W = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] trial_shear_force;
        logic signed [VAL_W-1:0] trial_normal_force;
        logic        [POS_W-1:0] peak_strength;
        logic        [POS_W-1:0] critical_opening;
    } side_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] shear_force;
        logic signed [VAL_W-1:0] normal_force;
    } res_t;
endpackage

[hw/rtl/ccfl_sqrt_stage.sv]
// One step of a restoring integer square root: two radicand bits per stage.
// Depends on ccfl_pkg for widths.
module ccfl_sqrt_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic [ccfl_pkg::SQ_W-1:0]   rem_in,
    input  logic [ccfl_pkg::ROOT_W-1:0] root_in,
    output logic [ccfl_pkg::SQ_W-1:0]   rem_out,
    output logic [ccfl_pkg::ROOT_W-1:0] root_out
);
    localparam int unsigned SH = 2 * (ccfl_pkg::ROOT_W - 1 - STEP);
    logic [ccfl_pkg::SQ_W+1:0] trial;

    always_comb
    begin
        // Candidate (4*root+1) placed at this digit position.
        trial = {{(ccfl_pkg::SQ_W+2-ccfl_pkg::ROOT_W-2){1'b0}}, root_in, 2'b01} << SH;
        if ({2'b00, rem_in} >= trial)
        begin
            rem_out  = rem_in - trial[ccfl_pkg::SQ_W-1:0];
            root_out = {root_in[ccfl_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out  = rem_in;
            root_out = {root_in[ccfl_pkg::ROOT_W-2:0], 1'b0};
        end
    end
endmodule

[hw/rtl/ccfl_divider.sv]
// Restoring divider step: one quotient bit of a 64-by-31 bit division.
// Depends on ccfl_pkg for widths.
module ccfl_divider (
    input  logic [ccfl_pkg::SQ_W-1:0]  num_in,
    input  logic [ccfl_pkg::POS_W:0]   rem_in,
    input  logic [ccfl_pkg::POS_W-1:0] den,
    output logic [ccfl_pkg::SQ_W-1:0]  num_out,
    output logic [ccfl_pkg::POS_W:0]   rem_out
);
    logic [ccfl_pkg::POS_W+1:0] cand;

    always_comb
    begin
        cand = {rem_in, num_in[ccfl_pkg::SQ_W-1]};
        num_out = {num_in[ccfl_pkg::SQ_W-2:0], 1'b0};
        // A zero divisor never subtracts, so its quotient stays zero.
        if (den != '0 && cand >= {2'b00, den})
        begin
            rem_out    = cand[ccfl_pkg::POS_W:0] - {1'b0, den};
            num_out[0] = 1'b1;
        end
        else
        begin
            rem_out = cand[ccfl_pkg::POS_W:0];
        end
    end
endmodule

[hw/rtl/coupled_cohesive_force_limiter_core.sv]
// Top level of the cohesive force limiter: squares, root, strength, clipping.
// Depends on ccfl_pkg, assert_macros.svh, ccfl_sqrt_stage and ccfl_divider.
//
// Channel | Direction | tdata fields (lowest first)
// s_axis  | in        | gap_shear, gap_normal, peak_strength, critical_opening,
//         |           | trial_shear_force, trial_normal_force (190 bits, pad 192)
// m_axis  | out       | shear_force, normal_force (64 bits)
//
// One item enters per cycle unless the output stalls. The pipeline has one stage
// for the squares, one per root bit, one for the strength product, one per
// quotient bit of the division, and one for the clipping. The pipeline is
// stateless apart from valid bits, which reset clears. A stall at the output
// freezes the whole pipeline in place, so nothing is lost or repeated.
`include "assert_macros.svh"
module coupled_cohesive_force_limiter_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // gs, gn, tau, dc, ts, tn from bit 0
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata   // shear_force, normal_force from bit 0
);
    localparam int unsigned RW = ccfl_pkg::ROOT_W;
    localparam int unsigned DW = ccfl_pkg::SQ_W;
    localparam int unsigned PW = ccfl_pkg::POS_W;
    localparam int unsigned NST = 1 + RW + 1 + DW + 1;

    logic adv;
    logic [NST-1:0] vld_reg;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    // Stage 0: magnitudes squared and summed.
    logic signed [31:0] gs, gn;
    logic [31:0] ags, agn;
    logic [DW-1:0] sum0_reg;
    ccfl_pkg::side_t side0_reg;
    assign gs  = s_axis_tdata[31:0];
    assign gn  = s_axis_tdata[63:32];
    assign ags = gs[31] ? 32'(-gs) : gs;
    assign agn = gn[31] ? 32'(-gn) : gn;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum0_reg <= DW'(ags) * DW'(ags) + DW'(agn) * DW'(agn);
            side0_reg.peak_strength      <= s_axis_tdata[94:64];
            side0_reg.critical_opening   <= s_axis_tdata[125:95];
            side0_reg.trial_shear_force  <= s_axis_tdata[157:126];
            side0_reg.trial_normal_force <= s_axis_tdata[189:158];
        end
    end

    // Root stages; entry k holds the state after k root bits.
    logic [DW-1:0] rrem_reg [1:RW];
    logic [RW-1:0] root_reg [1:RW];
    ccfl_pkg::side_t rside_reg [1:RW];
    for (genvar i = 0; i < RW; i++) begin : g_root
        logic [DW-1:0] rem_cur;
        logic [RW-1:0] root_cur;
        ccfl_pkg::side_t side_cur;
        logic [DW-1:0] rem_next;
        logic [RW-1:0] root_next;
        if (i == 0)
        begin : g_first
            assign rem_cur  = sum0_reg;
            assign root_cur = '0;
            assign side_cur = side0_reg;
        end
        else
        begin : g_rest
            assign rem_cur  = rrem_reg[i];
            assign root_cur = root_reg[i];
            assign side_cur = rside_reg[i];
        end
        ccfl_sqrt_stage #(.STEP(i)) u_stage (
            .rem_in(rem_cur), .root_in(root_cur),
            .rem_out(rem_next), .root_out(root_next)
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rrem_reg[i+1]  <= rem_next;
                root_reg[i+1]  <= root_next;
                rside_reg[i+1] <= side_cur;
            end
        end
    end

    // Product stage: tau * (dc - opening), or zero at or beyond critical.
    logic [DW-1:0] prod_reg;
    ccfl_pkg::side_t pside_reg;
    logic [RW-1:0] op;
    logic [PW-1:0] diff;
    assign op   = root_reg[RW];
    assign diff = PW'({1'b0, rside_reg[RW].critical_opening} - op);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (op < {1'b0, rside_reg[RW].critical_opening})
                prod_reg <= DW'(rside_reg[RW].peak_strength) * DW'(diff);
            else
                prod_reg <= '0;
            pside_reg <= rside_reg[RW];
        end
    end

    // Division stages, one quotient bit each; entry k holds k quotient bits.
    logic [DW-1:0] dnum_reg [1:DW];
    logic [PW:0]   drem_reg [1:DW];
    ccfl_pkg::side_t dside_reg [1:DW];
    for (genvar j = 0; j < DW; j++) begin : g_div
        logic [DW-1:0] num_cur;
        logic [PW:0]   rem_cur;
        ccfl_pkg::side_t side_cur;
        logic [DW-1:0] num_next;
        logic [PW:0]   rem_next;
        if (j == 0)
        begin : g_first
            assign num_cur  = prod_reg;
            assign rem_cur  = '0;
            assign side_cur = pside_reg;
        end
        else
        begin : g_rest
            assign num_cur  = dnum_reg[j];
            assign rem_cur  = drem_reg[j];
            assign side_cur = dside_reg[j];
        end
        ccfl_divider u_div (
            .num_in(num_cur), .rem_in(rem_cur),
            .den(side_cur.critical_opening),
            .num_out(num_next), .rem_out(rem_next)
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dnum_reg[j+1]  <= num_next;
                drem_reg[j+1]  <= rem_next;
                dside_reg[j+1] <= side_cur;
            end
        end
    end

    // Clip stage. The quotient never exceeds tau, so 31 bits hold it; a zero
    // critical opening gives a zero product and a divider that never
    // subtracts, hence zero strength.
    logic signed [31:0] s, ts, tn, ats;
    ccfl_pkg::res_t res_reg;
    assign s   = {1'b0, dnum_reg[DW][PW-1:0]};
    assign ts  = dside_reg[DW].trial_shear_force;
    assign tn  = dside_reg[DW].trial_normal_force;
    assign ats = ts[31] ? 32'(-ts) : ts;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.normal_force <= (tn < s) ? tn : s;
            if (ts[31] || $unsigned(ats) > $unsigned(s))
            begin
                if (ts[31] && !($unsigned(ats) > $unsigned(s)))
                    res_reg.shear_force <= ts;
                else
                    res_reg.shear_force <= ts[31] ? 32'(-s) : s;
            end
            else
                res_reg.shear_force <= ts;
        end
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = {res_reg.normal_force, res_reg.shear_force};

    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPL(a_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `ASSERT_IMPL(a_nf, clk, rst_n, m_axis_tvalid, !(res_reg.normal_force > $signed({1'b0, {31{1'b1}}})))
endmodule

[test/coupled_cohesive_force_limiter_core_test.sv]
// Self-checking testbench for the cohesive force limiter core: random and directed nodes,
// predicted clipped forces compared against every output transfer.
// Depends on coupled_cohesive_force_limiter_core and ccfl_pkg.
`timescale 1ns / 100ps
module coupled_cohesive_force_limiter_core_test;
    localparam int unsigned LATENCY   = 99;
    localparam int unsigned WATCHDOG  = 20000;
    localparam int unsigned HOLD_LEN  = 400;

    typedef struct packed {
        logic signed [31:0] gap_shear;
        logic signed [31:0] gap_normal;
        logic        [30:0] peak_strength;
        logic        [30:0] critical_opening;
        logic signed [31:0] trial_shear;
        logic signed [31:0] trial_normal;
    } node_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;   // gs, gn, tau, dc, ts, tn from bit 0
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // shear_force, normal_force from bit 0

    node_t pending_nodes[$];
    ccfl_pkg::res_t expected_forces[$];
    int    idle_phase;           // 0: receiver idles more, 1: sender idles more, 2: none
    bit    hold_receiver;
    bit    stimulus_done;
    int    n_mismatch = 0;
    int    n_checked = 0;
    int    quiet_cycles = 0;

    coupled_cohesive_force_limiter_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // Bitwise integer square root, rounded down.
    function automatic logic [31:0] floor_root(input logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_pos;
        rem = radicand;
        root = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > rem)
            bit_pos = bit_pos >> 2;
        while (bit_pos != 0)
        begin
            if (rem >= root + bit_pos)
            begin
                rem = rem - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end
            else
                root = root >> 1;
            bit_pos = bit_pos >> 2;
        end
        return root[31:0];
    endfunction

    // Linear softening law: strength falls from peak to zero at critical opening.
    function automatic ccfl_pkg::res_t limit_forces(input node_t n);
        logic [63:0]        mag_s;
        logic [63:0]        mag_n;
        logic [63:0]        opening;
        logic [63:0]        strength;
        logic signed [63:0] s_signed;
        logic signed [63:0] ts;
        logic signed [63:0] tn;
        logic [63:0]        mag_t;
        ccfl_pkg::res_t     r;
        mag_s = n.gap_shear < 0 ? -64'(n.gap_shear) : 64'(n.gap_shear);
        mag_n = n.gap_normal < 0 ? -64'(n.gap_normal) : 64'(n.gap_normal);
        opening = 64'(floor_root(mag_s * mag_s + mag_n * mag_n));
        strength = 0;
        if (opening < 64'(n.critical_opening))
            strength = (64'(n.peak_strength) * (64'(n.critical_opening) - opening))
                       / 64'(n.critical_opening);
        s_signed = strength;
        ts = n.trial_shear;
        tn = n.trial_normal;
        r.normal_force = tn < s_signed ? tn[31:0] : s_signed[31:0];
        mag_t = ts < 0 ? -ts : ts;
        r.shear_force = ts[31:0];
        if (mag_t > strength)
            r.shear_force = ts < 0 ? -s_signed[31:0] : s_signed[31:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
            default: return $urandom;
        endcase
    endfunction

    // Mostly nodes whose opening sits near the critical opening, so the softening
    // slope, not just the extremes, gets exercised.
    function automatic node_t random_node();
        node_t n;
        n.gap_shear = rand_val();
        n.gap_normal = rand_val();
        n.peak_strength = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
        if ($urandom_range(0, 3) == 0)
            n.critical_opening = 31'($urandom) | 31'd1;
        else
        begin
            n.gap_shear = 32'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
            n.gap_normal = 32'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
            n.critical_opening = 31'($urandom_range(1, 32'h0004_0000));
        end
        n.trial_shear = rand_val();
        n.trial_normal = rand_val();
        return n;
    endfunction

    function automatic node_t make_node(input logic [31:0] gs, input logic [31:0] gn,
                                        input logic [30:0] tau, input logic [30:0] dc,
                                        input logic [31:0] ts, input logic [31:0] tn);
        node_t n;
        n.gap_shear = gs;
        n.gap_normal = gn;
        n.peak_strength = tau;
        n.critical_opening = dc;
        n.trial_shear = ts;
        n.trial_normal = tn;
        return n;
    endfunction

    // Driver: offers the head of the queue, idling at random per the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_forces.push_back(limit_forces(pending_nodes.pop_front()));
            end
            if ((!s_axis_tvalid || s_axis_tready) )
            begin
                if (pending_nodes.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                    && !(idle_phase == 0 && $urandom_range(0, 99) < 33)
                    && !(idle_phase == 1 && $urandom_range(0, 99) < 45))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00,
                                      pending_nodes[0].trial_normal, pending_nodes[0].trial_shear,
                                      pending_nodes[0].critical_opening,
                                      pending_nodes[0].peak_strength,
                                      pending_nodes[0].gap_normal, pending_nodes[0].gap_shear};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: receiver readiness plus the field by field check of each result.
    always @(posedge clk or negedge rst_n)
    begin
        ccfl_pkg::res_t got;
        ccfl_pkg::res_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.shear_force  = m_axis_tdata[31:0];
                got.normal_force = m_axis_tdata[63:32];
                n_checked <= n_checked + 1;
                if (expected_forces.size() == 0)
                begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_forces.pop_front();
                    if (got.shear_force !== want.shear_force
                        || got.normal_force !== want.normal_force)
                    begin
                        n_mismatch <= n_mismatch + 1;
                        if (n_mismatch < 10)
                            $display("mismatch: shear exp %h got %h, normal exp %h got %h",
                                     want.shear_force, got.shear_force,
                                     want.normal_force, got.normal_force);
                    end
                end
            end
            if (hold_receiver)
                m_axis_tready <= 1'b0;
            else if (idle_phase == 0)
                m_axis_tready <= $urandom_range(0, 99) >= 45;
            else if (idle_phase == 1)
                m_axis_tready <= $urandom_range(0, 99) >= 33;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (rst_n && !(stimulus_done && expected_forces.size() == 0))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("coupled_cohesive_force_limiter_core_test: done, errors");
                $finish;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering, to fill the pipeline.
    initial
    begin
        hold_receiver = 1'b0;
        wait (idle_phase == 2);
        repeat (50) @(posedge clk);
        hold_receiver <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_receiver <= 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        idle_phase = 0;
        stimulus_done = 1'b0;

        // Directed nodes: extremes, opening beyond critical, zero and most negative
        // trial shear, zero peak strength, minimal critical opening.
        pending_nodes.push_back(make_node(0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_nodes.push_back(make_node(0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                          32'h8000_0000, 32'h8000_0000));
        pending_nodes.push_back(make_node(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                                          31'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000));
        pending_nodes.push_back(make_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0001_0000, 31'd1,
                                          32'hFFFF_0000, 32'hFFFF_0000));
        pending_nodes.push_back(make_node(32'h0001_0000, 0, 31'h0001_0000, 31'h0002_0000,
                                          0, 32'h0001_0000));
        pending_nodes.push_back(make_node(32'h0001_0000, 0, 31'h0001_0000, 31'h0002_0000,
                                          32'h8000_0000, 32'h0000_4000));
        pending_nodes.push_back(make_node(0, 32'h0002_0000, 31'h0001_0000, 31'h0002_0000,
                                          32'h0000_1000, 32'hFFFF_F000));
        pending_nodes.push_back(make_node(32'hFFFF_0000, 32'h0001_0000, 0, 31'h0003_0000,
                                          32'h0000_0100, 32'h0000_0100));
        pending_nodes.push_back(make_node(32'h0003_0000, 32'h0004_0000, 31'h0010_0000,
                                          31'h0005_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_nodes.push_back(make_node(32'h0003_0000, 32'hFFFC_0000, 31'h0010_0000,
                                          31'h0005_0001, 32'h8000_0001, 32'h8000_0001));
        pending_nodes.push_back(make_node(1, 1, 31'h7FFF_FFFF, 31'd2, 32'h0000_0001, 0));
        pending_nodes.push_back(make_node(32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555,
                                          31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        pending_nodes.push_back(make_node(32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA,
                                          31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Random nodes in three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int k = 0; k < 212; k++)
                pending_nodes.push_back(random_node());
            idle_phase = phase;
            wait (pending_nodes.size() == 0);
        end
        stimulus_done = 1'b1;
        wait (expected_forces.size() == 0 && !s_axis_tvalid);
        repeat (LATENCY + 20) @(posedge clk);

        $display("covered %0d nodes: softening slope, fully opened, zero and extreme forces,",
                 n_checked);
        $display("three idling mixes and one long output stall");
        if (n_mismatch == 0 && expected_forces.size() == 0)
            $display("coupled_cohesive_force_limiter_core_test: done, clean");
        else
            $display("coupled_cohesive_force_limiter_core_test: done, errors");
        $finish;
    end
endmodule
